/* design/dq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_pkg
// Shared sizes, opcodes and cell command types for the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

   localparam int DEPTH  = 16;
   localparam int DATA_W = 32;
   localparam int OP_W   = 3;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_POP_BACK   = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_CLEAR      = 3'd4,
      OP_QUERY      = 3'd5
   } opcode_type;

   // Command broadcast to every cell in the row
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_SHIFT_RIGHT,
      CELL_SHIFT_LEFT,
      CELL_APPEND,
      CELL_TRIM,
      CELL_CLEAR
   } cell_cmd_type;

   // What one cell shows its neighbors
   typedef struct packed {
      logic              valid;
      logic [DATA_W-1:0] data;
   } link_type;

endpackage
`default_nettype wire

/* design/dq_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_cell
// One slot of the queue row: holds a word and its valid bit, and trades
// them with its left and right neighbors under a shared command.
// ----------------------------------------------------------------------------
module dq_cell
   import dq_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cell_cmd_type      cmd,
   input  wire logic [DATA_W-1:0] push_value,
   input  wire link_type          left_in,
   input  wire link_type          right_in,
   output link_type               cell_out
);

   logic              valid_ff, valid_in;
   logic [DATA_W-1:0] data_ff, data_in;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      case (cmd)
         CELL_SHIFT_RIGHT: begin
            valid_in = left_in.valid;
            data_in  = left_in.data;
         end
         CELL_SHIFT_LEFT: begin
            valid_in = right_in.valid;
            data_in  = right_in.data;
         end
         CELL_APPEND: begin
            // first empty slot after the occupied run takes the word
            if (!valid_ff && left_in.valid) begin
               valid_in = 1'b1;
               data_in  = push_value;
            end
         end
         CELL_TRIM: begin
            // drop the last occupied slot
            if (valid_ff && !right_in.valid) begin
               valid_in = 1'b0;
            end
         end
         CELL_CLEAR: valid_in = 1'b0;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign cell_out.valid = valid_ff;
   assign cell_out.data  = data_ff;

endmodule
`default_nettype wire

/* design/double_ended_queue_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Bounded deque of signed words kept in a row of shifting cells; the front
// word always sits in the first cell.
// ----------------------------------------------------------------------------
// Result path: an accepted request is held as pending; the result registers
// load it once the output is free. Throughput: one request per cycle while
// results are taken; the cells update at accept and are read at that load.
// Reset: synchronous; clears the count, the cell valid bits, the pending
// result and the result valid. Stored words are not reset.
module double_ended_queue_top
   import dq_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [OP_W-1:0]          req_opcode,
   input  wire logic signed [DATA_W-1:0] req_push_value,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic signed [DATA_W-1:0]      rsp_popped_value,
   output logic signed [DATA_W-1:0]      rsp_front_value,
   output logic signed [DATA_W-1:0]      rsp_back_value,
   output logic [CNT_W-1:0]              rsp_item_count,
   output logic                          rsp_is_empty,
   output logic                          rsp_overflow,
   output logic                          rsp_underflow
);

   link_type     cell_out [DEPTH];
   link_type     left_in  [DEPTH];
   link_type     right_in [DEPTH];
   cell_cmd_type cmd;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic              pend_ff, pend_in;
   logic [DATA_W-1:0] pop_val_ff, pop_val_in;
   logic              ovf_ff, ovf_in, udf_ff, udf_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_popped_ff, rsp_front_ff, rsp_back_ff;
   logic [CNT_W-1:0]  rsp_count_ff;
   logic              rsp_empty_ff, rsp_ovf_ff, rsp_udf_ff;

   logic              accept, out_free, load, full, empty;
   logic [DATA_W-1:0] front_now, back_now;

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         if (gi == 0) begin : g_first
            assign left_in[gi].valid = 1'b1;
            assign left_in[gi].data  = req_push_value;
         end else begin : g_mid_l
            assign left_in[gi] = cell_out[gi-1];
         end
         if (gi == DEPTH - 1) begin : g_last
            assign right_in[gi].valid = 1'b0;
            assign right_in[gi].data  = '0;
         end else begin : g_mid_r
            assign right_in[gi] = cell_out[gi+1];
         end
         dq_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cmd        (cmd),
            .push_value (req_push_value),
            .left_in    (left_in[gi]),
            .right_in   (right_in[gi]),
            .cell_out   (cell_out[gi])
         );
      end
   endgenerate

   // Back word: the one occupied cell whose right neighbor is empty
   always_comb begin
      back_now = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (cell_out[i].valid && !right_in[i].valid) begin
            back_now = back_now | cell_out[i].data;
         end
      end
   end

   assign front_now = cell_out[0].valid ? cell_out[0].data : '0;
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign load      = pend_ff && out_free;
   assign req_ready = !pend_ff || out_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd        = CELL_HOLD;
      count_in   = count_ff;
      pop_val_in = '0;
      ovf_in     = 1'b0;
      udf_in     = 1'b0;
      if (accept) begin
         unique case (req_opcode)
            OP_PUSH_BACK: begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  cmd      = CELL_APPEND;
                  count_in = count_ff + 1'b1;
               end
            end
            OP_PUSH_FRONT: begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  cmd      = CELL_SHIFT_RIGHT;
                  count_in = count_ff + 1'b1;
               end
            end
            OP_POP_BACK: begin
               if (empty) begin
                  udf_in = 1'b1;
               end else begin
                  cmd        = CELL_TRIM;
                  pop_val_in = back_now;
                  count_in   = count_ff - 1'b1;
               end
            end
            OP_POP_FRONT: begin
               if (empty) begin
                  udf_in = 1'b1;
               end else begin
                  cmd        = CELL_SHIFT_LEFT;
                  pop_val_in = front_now;
                  count_in   = count_ff - 1'b1;
               end
            end
            OP_CLEAR: begin
               cmd      = CELL_CLEAR;
               count_in = '0;
            end
            default: ;
         endcase
      end
   end

   assign pend_in      = accept ? 1'b1 : (load ? 1'b0 : pend_ff);
   assign rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      // hold the popped word and flags until the result is formed
      if (accept) begin
         pop_val_ff <= pop_val_in;
         ovf_ff     <= ovf_in;
         udf_ff     <= udf_in;
      end
      if (load) begin
         rsp_popped_ff <= pop_val_ff;
         rsp_front_ff  <= front_now;
         rsp_back_ff   <= back_now;
         rsp_count_ff  <= count_ff;
         rsp_empty_ff  <= empty;
         rsp_ovf_ff    <= ovf_ff;
         rsp_udf_ff    <= udf_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_popped_value = rsp_popped_ff;
   assign rsp_front_value  = rsp_front_ff;
   assign rsp_back_value   = rsp_back_ff;
   assign rsp_item_count   = rsp_count_ff;
   assign rsp_is_empty     = rsp_empty_ff;
   assign rsp_overflow     = rsp_ovf_ff;
   assign rsp_underflow    = rsp_udf_ff;

endmodule
`default_nettype wire

/* sim/double_ended_queue_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_top_test
// Self-checking bench for the deque. A clocked driver feeds requests from a
// list built up front, a ring model predicts every response, and a clocked
// monitor compares each response field by field against the oldest
// prediction. Sender bursts, receiver stalls, one long receiver hold-off and
// two drain pauses exercise back-pressure.
// ----------------------------------------------------------------------------
module double_ended_queue_top_test;
   import dq_pkg::*;

   localparam int NUM_RANDOM  = 1800;
   localparam int IDLE_LIMIT  = 5000;
   localparam int HOLD_CYCLES = 300;
   localparam int HOLD_AFTER  = 400;

   // Codes outside the named set behave as a query
   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

   typedef struct {
      logic [OP_W-1:0]   opcode;
      logic [DATA_W-1:0] push_value;
      bit                drain;
   } deque_req_type;

   typedef struct {
      logic [DATA_W-1:0] popped_value;
      logic [DATA_W-1:0] front_value;
      logic [DATA_W-1:0] back_value;
      logic [CNT_W-1:0]  item_count;
      logic              is_empty;
      logic              overflow;
      logic              underflow;
   } deque_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [OP_W-1:0]          req_opcode = OP_QUERY;
   logic signed [DATA_W-1:0] req_push_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [DATA_W-1:0] rsp_popped_value;
   logic signed [DATA_W-1:0] rsp_front_value;
   logic signed [DATA_W-1:0] rsp_back_value;
   logic [CNT_W-1:0]         rsp_item_count;
   logic                     rsp_is_empty;
   logic                     rsp_overflow;
   logic                     rsp_underflow;

   deque_req_type    pending_reqs[$];
   deque_result_type expected_results[$];

   // Ring model state
   logic [DATA_W-1:0] ring_words[DEPTH];
   int                ring_head = 0;
   int                ring_fill = 0;

   logic tb_active = 1'b0;
   logic req_taken = 1'b0;
   int   failures = 0;
   int   results_seen = 0;
   int   idle_cycles = 0;
   int   burst_left = 0;
   int   send_gap = 0;
   int   stall_mode = 0;
   int   stall_left = 0;
   int   hold_off_left = 0;
   bit   hold_off_done = 1'b0;

   double_ended_queue_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_push_value   (req_push_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_popped_value (rsp_popped_value),
      .rsp_front_value  (rsp_front_value),
      .rsp_back_value   (rsp_back_value),
      .rsp_item_count   (rsp_item_count),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_overflow     (rsp_overflow),
      .rsp_underflow    (rsp_underflow)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic add_req(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val,
                          input bit drain = 1'b0);
      deque_req_type item;
      item.opcode     = op;
      item.push_value = val;
      item.drain      = drain;
      pending_reqs.insert(pending_reqs.size(), item);
   endtask

   task automatic predict_deque(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val,
                                output deque_result_type res);
      res = '{default: '0};
      case (op)
         OP_PUSH_BACK: begin
            if (ring_fill >= DEPTH) begin
               res.overflow = 1'b1;
            end else begin
               ring_words[(ring_head + ring_fill) % DEPTH] = val;
               ring_fill++;
            end
         end
         OP_PUSH_FRONT: begin
            if (ring_fill >= DEPTH) begin
               res.overflow = 1'b1;
            end else begin
               ring_head = (ring_head + DEPTH - 1) % DEPTH;
               ring_words[ring_head] = val;
               ring_fill++;
            end
         end
         OP_POP_BACK: begin
            if (ring_fill == 0) begin
               res.underflow = 1'b1;
            end else begin
               res.popped_value = ring_words[(ring_head + ring_fill - 1) % DEPTH];
               ring_fill--;
            end
         end
         OP_POP_FRONT: begin
            if (ring_fill == 0) begin
               res.underflow = 1'b1;
            end else begin
               res.popped_value = ring_words[ring_head];
               ring_head = (ring_head + 1) % DEPTH;
               ring_fill--;
            end
         end
         OP_CLEAR: begin
            ring_fill = 0;
            ring_head = 0;
         end
         default: ;
      endcase
      if (ring_fill != 0) begin
         res.front_value = ring_words[ring_head];
         res.back_value  = ring_words[(ring_head + ring_fill - 1) % DEPTH];
      end
      res.item_count = ring_fill[CNT_W-1:0];
      res.is_empty   = (ring_fill == 0);
   endtask

   task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                              input logic [DATA_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         failures++;
      end
   endtask

   function automatic logic [DATA_W-1:0] pick_word();
      case ($urandom_range(0, 9))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // Sender: bursts of requests separated by random gaps
   always @(negedge clock) begin : sender
      logic          drive_valid;
      deque_req_type item;
      drive_valid = req_valid;
      if (!tb_active) begin
         drive_valid = 1'b0;
      end else if (req_valid && !req_taken) begin
         // hold the offered request
      end else begin
         drive_valid = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
         end else if (pending_reqs.size() != 0 &&
                      !(pending_reqs[0].drain && expected_results.size() != 0)) begin
            item = pending_reqs[0];
            pending_reqs.delete(0);
            req_opcode     <= item.opcode;
            req_push_value <= item.push_value;
            drive_valid = 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 40);
               send_gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
      end
      req_valid <= drive_valid;
   end

   // Receiver: stall pattern of its own plus one long hold-off
   always @(negedge clock) begin : receiver
      logic take;
      take = 1'b0;
      if (hold_off_left > 0) begin
         hold_off_left--;
      end else if (!hold_off_done && results_seen >= HOLD_AFTER) begin
         hold_off_done = 1'b1;
         hold_off_left = HOLD_CYCLES;
      end else begin
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(10, 80);
         end
         stall_left--;
         case (stall_mode)
            0: take = 1'b1;
            1: take = $urandom_range(0, 1);
            default: take = ($urandom_range(0, 4) == 0);
         endcase
      end
      rsp_ready <= take;
   end

   always @(posedge clock) begin : monitor
      deque_result_type exp_res;
      if (reset) begin
         tb_active <= 1'b0;
         req_taken <= 1'b0;
      end else begin
         tb_active <= 1'b1;
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            predict_deque(req_opcode, req_push_value, exp_res);
            expected_results.insert(expected_results.size(), exp_res);
         end
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               $display("%0t: response with none expected, expected nothing, actual count %0d",
                        $time, rsp_item_count);
               failures++;
            end else begin
               exp_res = expected_results[0];
               expected_results.delete(0);
               check_field("popped_value", exp_res.popped_value, rsp_popped_value);
               check_field("front_value", exp_res.front_value, rsp_front_value);
               check_field("back_value", exp_res.back_value, rsp_back_value);
               check_field("item_count", DATA_W'(exp_res.item_count),
                           DATA_W'(rsp_item_count));
               check_field("is_empty", DATA_W'(exp_res.is_empty), DATA_W'(rsp_is_empty));
               check_field("overflow", DATA_W'(exp_res.overflow), DATA_W'(rsp_overflow));
               check_field("underflow", DATA_W'(exp_res.underflow),
                           DATA_W'(rsp_underflow));
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int                push_bias;
      int                phase_left;
      int                pick;
      logic [OP_W-1:0]   op;
      foreach (ring_words[i]) ring_words[i] = '0;

      // Directed: empty queue, extremes, both ends, spare codes, clear
      add_req(OP_QUERY, 32'h1234_5678);
      add_req(OP_POP_BACK, '0);
      add_req(OP_POP_FRONT, '0);
      add_req(OP_PUSH_BACK, 32'h7fff_ffff);
      add_req(OP_PUSH_FRONT, 32'h8000_0000);
      add_req(OP_PUSH_BACK, 32'hffff_ffff);
      add_req(OP_PUSH_FRONT, 32'h0000_0000);
      add_req(OP_SPARE_LO, 32'hdead_beef);
      add_req(OP_SPARE_HI, 32'h5555_aaaa);
      add_req(OP_POP_BACK, '0);
      add_req(OP_POP_FRONT, '0);
      add_req(OP_CLEAR, 32'hffff_ffff);
      add_req(OP_QUERY, '0);
      add_req(OP_POP_FRONT, '0);
      add_req(OP_PUSH_FRONT, 32'h0000_0001);
      add_req(OP_POP_BACK, '0);

      // Random: phases that lean toward pushes or pops reach full and empty
      push_bias  = 50;
      phase_left = 0;
      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (phase_left == 0) begin
            case ($urandom_range(0, 2))
               0: push_bias = 85;
               1: push_bias = 15;
               default: push_bias = 50;
            endcase
            phase_left = $urandom_range(40, 80);
         end
         phase_left--;
         pick = $urandom_range(0, 99);
         if (pick < 2) begin
            op = OP_CLEAR;
         end else if (pick < 5) begin
            op = OP_QUERY;
         end else if (pick < 6) begin
            op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
         end else if ($urandom_range(0, 99) < push_bias) begin
            op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
         end else begin
            op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
         end
         // pause the sender until the deque has answered everything
         add_req(op, pick_word(), (n == 0) || (n == NUM_RANDOM / 2));
      end

      repeat (4) @(negedge clock);
      reset = 1'b0;

      do @(negedge clock); while (pending_reqs.size() != 0 || req_valid);
      do @(negedge clock); while (expected_results.size() != 0);
      repeat (10) @(negedge clock);

      if (expected_results.size() != 0) begin
         $display("%0t: %0d responses missing, expected 0 left, actual %0d left",
                  $time, expected_results.size(), expected_results.size());
         failures++;
      end
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
design/dq_pkg.sv
design/dq_cell.sv
design/double_ended_queue_top.sv
sim/double_ended_queue_top_test.sv
